// File: rtl/rvx_pkg.sv
// shared types, opcodes and operation codes for the rv32i decode/execute unit
package rvx_pkg;

   // major opcodes
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   localparam logic [31:0] CLEAR_BIT0 = ~32'd1;

   // operation codes
   localparam logic [5:0] OP_INVALID = 6'd0;
   localparam logic [5:0] OP_LUI     = 6'd1;
   localparam logic [5:0] OP_AUIPC   = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_JALR    = 6'd4;
   localparam logic [5:0] OP_BEQ     = 6'd5;
   localparam logic [5:0] OP_BNE     = 6'd6;
   localparam logic [5:0] OP_BLT     = 6'd7;
   localparam logic [5:0] OP_BGE     = 6'd8;
   localparam logic [5:0] OP_BLTU    = 6'd9;
   localparam logic [5:0] OP_BGEU    = 6'd10;
   localparam logic [5:0] OP_LB      = 6'd11;
   localparam logic [5:0] OP_LH      = 6'd12;
   localparam logic [5:0] OP_LW      = 6'd13;
   localparam logic [5:0] OP_LBU     = 6'd14;
   localparam logic [5:0] OP_LHU     = 6'd15;
   localparam logic [5:0] OP_SB      = 6'd16;
   localparam logic [5:0] OP_SH      = 6'd17;
   localparam logic [5:0] OP_SW      = 6'd18;
   localparam logic [5:0] OP_ADDI    = 6'd19;
   localparam logic [5:0] OP_SLTI    = 6'd20;
   localparam logic [5:0] OP_SLTIU   = 6'd21;
   localparam logic [5:0] OP_XORI    = 6'd22;
   localparam logic [5:0] OP_ORI     = 6'd23;
   localparam logic [5:0] OP_ANDI    = 6'd24;
   localparam logic [5:0] OP_SLLI    = 6'd25;
   localparam logic [5:0] OP_SRLI    = 6'd26;
   localparam logic [5:0] OP_SRAI    = 6'd27;
   localparam logic [5:0] OP_ADD     = 6'd28;
   localparam logic [5:0] OP_SUB     = 6'd29;
   localparam logic [5:0] OP_SLL     = 6'd30;
   localparam logic [5:0] OP_SLT     = 6'd31;
   localparam logic [5:0] OP_SLTU    = 6'd32;
   localparam logic [5:0] OP_XOR     = 6'd33;
   localparam logic [5:0] OP_SRL     = 6'd34;
   localparam logic [5:0] OP_SRA     = 6'd35;
   localparam logic [5:0] OP_OR      = 6'd36;
   localparam logic [5:0] OP_AND     = 6'd37;

   typedef struct packed {
      logic [31:0] instruction_word;
      logic [31:0] src1_value;
      logic [31:0] src2_value;
      logic [31:0] pc_value;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic [4:0]  dest_reg;
      logic        writes_dest;
      logic [5:0]  operation_id;
      logic        redirect;
      logic [31:0] target_address;
      logic [31:0] store_data;
      logic        invalid;
   } rsp_type;

   // classified instruction handed from decode to execute
   typedef struct packed {
      logic [5:0]  op;
      logic [4:0]  rd;
      logic        wr;
      logic [31:0] imm;
      logic [31:0] src1;
      logic [31:0] src2;
      logic [31:0] pc;
   } dec_type;

endpackage

// File: rtl/rvx_decode.sv
// front end: accepts a request, decodes the operation and builds its immediate
module rvx_decode (
   input  rvx_pkg::req_type req_data,
   input  logic             start,
   input  logic             busy,
   output logic             push,
   output rvx_pkg::dec_type dec
);
   import rvx_pkg::*;

   logic [31:0] ir;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
   logic [5:0]  op;
   logic [31:0] imm;

   assign ir    = req_data.instruction_word;
   assign opc   = ir[6:0];
   assign f3    = ir[14:12];
   assign f7    = ir[31:25];
   assign imm_i = {{20{ir[31]}}, ir[31:20]};
   assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
   assign imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
   assign imm_u = {ir[31:12], 12'b0};
   assign imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};

   always_comb begin
      op  = OP_INVALID;
      imm = imm_i;
      unique case (opc)
         OPC_LUI: begin
            op  = OP_LUI;
            imm = imm_u;
         end
         OPC_AUIPC: begin
            op  = OP_AUIPC;
            imm = imm_u;
         end
         OPC_JAL: begin
            op  = OP_JAL;
            imm = imm_j;
         end
         OPC_JALR: begin
            if (f3 == 3'd0) op = OP_JALR;
         end
         OPC_BRANCH: begin
            imm = imm_b;
            unique case (f3)
               3'd0:    op = OP_BEQ;
               3'd1:    op = OP_BNE;
               3'd4:    op = OP_BLT;
               3'd5:    op = OP_BGE;
               3'd6:    op = OP_BLTU;
               3'd7:    op = OP_BGEU;
               default: op = OP_INVALID;
            endcase
         end
         OPC_LOAD: begin
            unique case (f3)
               3'd0:    op = OP_LB;
               3'd1:    op = OP_LH;
               3'd2:    op = OP_LW;
               3'd4:    op = OP_LBU;
               3'd5:    op = OP_LHU;
               default: op = OP_INVALID;
            endcase
         end
         OPC_STORE: begin
            imm = imm_s;
            unique case (f3)
               3'd0:    op = OP_SB;
               3'd1:    op = OP_SH;
               3'd2:    op = OP_SW;
               default: op = OP_INVALID;
            endcase
         end
         OPC_OPIMM: begin
            unique case (f3)
               3'd0: op = OP_ADDI;
               3'd1: op = (f7 == F7_BASE) ? OP_SLLI : OP_INVALID;
               3'd2: op = OP_SLTI;
               3'd3: op = OP_SLTIU;
               3'd4: op = OP_XORI;
               3'd5: begin
                  if (f7 == F7_BASE)     op = OP_SRLI;
                  else if (f7 == F7_ALT) op = OP_SRAI;
                  else                   op = OP_INVALID;
               end
               3'd6: op = OP_ORI;
               default: op = OP_ANDI;
            endcase
         end
         OPC_OP: begin
            if (f7 == F7_BASE) begin
               unique case (f3)
                  3'd0: op = OP_ADD;
                  3'd1: op = OP_SLL;
                  3'd2: op = OP_SLT;
                  3'd3: op = OP_SLTU;
                  3'd4: op = OP_XOR;
                  3'd5: op = OP_SRL;
                  3'd6: op = OP_OR;
                  default: op = OP_AND;
               endcase
            end else if (f7 == F7_ALT && f3 == 3'd0) begin
               op = OP_SUB;
            end else if (f7 == F7_ALT && f3 == 3'd5) begin
               op = OP_SRA;
            end
         end
         default: op = OP_INVALID;
      endcase
   end

   assign push     = start & ~busy;
   assign dec.op   = op;
   assign dec.rd   = ir[11:7];
   // branches and stores leave the register file alone
   assign dec.wr   = (op != OP_INVALID) && !(op >= OP_BEQ && op <= OP_BGEU)
                     && !(op >= OP_SB && op <= OP_SW);
   assign dec.imm  = imm;
   assign dec.src1 = req_data.src1_value;
   assign dec.src2 = req_data.src2_value;
   assign dec.pc   = req_data.pc_value;

endmodule

// File: rtl/rvx_queue.sv
// small fifo between the decode front end and the execute back end
module rvx_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rvx_pkg::dec_type push_data,
   input  logic             pop,
   output rvx_pkg::dec_type pop_data,
   output logic             empty,
   output logic             full
);
   import rvx_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dec_type           entry_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign empty    = (count_ff == CNT_W'(0));
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: rtl/rvx_execute.sv
// back end: alu, address and branch resolution, registered result
module rvx_execute (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  rvx_pkg::dec_type dec,
   output logic             pop,
   output logic             rsp_valid,
   output rvx_pkg::rsp_type rsp_data
);
   import rvx_pkg::*;

   logic        valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] a, opb, sum, link, pc_tgt;
   logic [4:0]  shamt;
   logic        lt_s, lt_u, eq, taken;

   // back end never stalls: take whatever the queue holds
   assign pop = ~empty;

   assign a      = dec.src1;
   assign opb    = (dec.op >= OP_ADD) ? dec.src2 : dec.imm;
   assign shamt  = opb[4:0];
   assign sum    = a + opb;
   assign link   = dec.pc + 32'd4;
   assign pc_tgt = dec.pc + dec.imm;
   assign eq     = (a == dec.src2);
   assign lt_s   = ($signed(a) < $signed(opb));
   assign lt_u   = (a < opb);

   always_comb begin
      case (dec.op)
         OP_BEQ:  taken = eq;
         OP_BNE:  taken = ~eq;
         OP_BLT:  taken = ($signed(a) < $signed(dec.src2));
         OP_BGE:  taken = ~($signed(a) < $signed(dec.src2));
         OP_BLTU: taken = (a < dec.src2);
         OP_BGEU: taken = ~(a < dec.src2);
         default: taken = 1'b0;
      endcase
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.operation_id   = dec.op;
      rsp_in.invalid        = (dec.op == OP_INVALID);
      rsp_in.writes_dest    = dec.wr;
      rsp_in.dest_reg       = dec.wr ? dec.rd : 5'd0;
      case (dec.op) inside
         OP_LUI:   rsp_in.result_value = dec.imm;
         OP_AUIPC: rsp_in.result_value = pc_tgt;
         OP_JAL: begin
            rsp_in.result_value   = link;
            rsp_in.redirect       = 1'b1;
            rsp_in.target_address = pc_tgt;
         end
         OP_JALR: begin
            rsp_in.result_value   = link;
            rsp_in.redirect       = 1'b1;
            rsp_in.target_address = sum & CLEAR_BIT0;
         end
         OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
            rsp_in.redirect       = taken;
            rsp_in.target_address = taken ? pc_tgt : 32'd0;
         end
         OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: rsp_in.result_value = sum;
         OP_SB, OP_SH, OP_SW: begin
            rsp_in.result_value = sum;
            rsp_in.store_data   = dec.src2;
         end
         OP_ADDI, OP_ADD:  rsp_in.result_value = sum;
         OP_SUB:           rsp_in.result_value = a - opb;
         OP_SLTI, OP_SLT:  rsp_in.result_value = {31'd0, lt_s};
         OP_SLTIU, OP_SLTU: rsp_in.result_value = {31'd0, lt_u};
         OP_XORI, OP_XOR:  rsp_in.result_value = a ^ opb;
         OP_ORI, OP_OR:    rsp_in.result_value = a | opb;
         OP_ANDI, OP_AND:  rsp_in.result_value = a & opb;
         OP_SLLI, OP_SLL:  rsp_in.result_value = a << shamt;
         OP_SRLI, OP_SRL:  rsp_in.result_value = a >> shamt;
         OP_SRAI, OP_SRA:  rsp_in.result_value = $unsigned($signed(a) >>> shamt);
         default:          rsp_in.result_value = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/rv32i_decode_execute.sv
// top level of the rv32i decode and execute unit
// One RV32I instruction with its two source values and pc is taken per clock
// (start high while busy is low); its result shows on rsp_data for exactly one
// cycle with rsp_valid high. The accepting edge writes the decoded request into
// the queue, and the execute stage then registers its result in rsp_ff. The
// receiver cannot stall, so the execute side pops the queue whenever it is not
// empty; with the default QUEUE_DEPTH the queue never holds more than one
// request and busy stays low after reset, so a request is taken in every cycle
// if offered. Results come out in request order, and an unsupported encoding
// returns invalid with all other fields zero.
module rv32i_decode_execute #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rvx_pkg::req_type req_data,
   output logic             rsp_valid,
   output rvx_pkg::rsp_type rsp_data
);
   import rvx_pkg::*;

   dec_type dec_front, dec_back;
   logic    push, pop, empty, full;

   assign busy = full;

   rvx_decode u_decode (
      .req_data (req_data),
      .start    (start),
      .busy     (busy),
      .push     (push),
      .dec      (dec_front)
   );

   rvx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (dec_front),
      .pop       (pop),
      .pop_data  (dec_back),
      .empty     (empty),
      .full      (full)
   );

   rvx_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .dec       (dec_back),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // every accepted request comes back through the queue and the result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted request produced no result");

   // a result with no request behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching request");

   // invalid results carry nothing else
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.invalid) |->
      (!rsp_data.writes_dest && !rsp_data.redirect &&
       rsp_data.operation_id == OP_INVALID && rsp_data.result_value == 32'd0))
      else $error("invalid result with live fields");

   // execute pops any waiting entry, so the default-depth queue never backs up
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("queue filled although the receiver cannot stall");

endmodule

// File: test/rv32i_exec_checker.sv
// funct3 names and the result checker for the rv32i decode/execute unit
`timescale 1ns / 100ps

package rv32i_tb_pkg;
   localparam logic [2:0] F3_ADD_SUB = 3'd0;
   localparam logic [2:0] F3_SLL     = 3'd1;
   localparam logic [2:0] F3_SLT     = 3'd2;
   localparam logic [2:0] F3_SLTU    = 3'd3;
   localparam logic [2:0] F3_XOR     = 3'd4;
   localparam logic [2:0] F3_SRL_SRA = 3'd5;
   localparam logic [2:0] F3_OR      = 3'd6;
   localparam logic [2:0] F3_AND     = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   localparam logic [2:0] F3_SB = 3'd0;
   localparam logic [2:0] F3_SH = 3'd1;
   localparam logic [2:0] F3_SW = 3'd2;

   localparam logic [2:0] F3_JALR = 3'd0;
endpackage

module rv32i_exec_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  rvx_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  rvx_pkg::rsp_type rsp_data,
   output int               pending_count,
   output int               error_count
);
   import rvx_pkg::*;
   import rv32i_tb_pkg::*;

   rsp_type expected_results[$];
   rsp_type want;
   int      mismatch_total = 0;

   assign error_count = mismatch_total;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_total++;
   endtask

   function automatic logic [31:0] alu_value(input logic [2:0] f3, input logic alt,
                                             input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      case (f3)
         F3_ADD_SUB: r = alt ? a - b : a + b;
         F3_SLL:     r = a << b[4:0];
         F3_SLT:     r = {31'd0, $signed(a) < $signed(b)};
         F3_SLTU:    r = {31'd0, a < b};
         F3_XOR:     r = a ^ b;
         F3_SRL_SRA: begin
            // kept apart so the arithmetic shift stays signed
            if (alt) r = $signed(a) >>> b[4:0];
            else r = a >> b[4:0];
         end
         F3_OR:      r = a | b;
         default:    r = a & b;
      endcase
      return r;
   endfunction

   function automatic rsp_type execute_instruction(input req_type r);
      logic [31:0] ir, a, b, pc;
      logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
      logic [31:0] res, tgt, sdata;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [5:0]  op;
      logic        wr, redir, taken;
      rsp_type     o;
      ir = r.instruction_word;
      a  = r.src1_value;
      b  = r.src2_value;
      pc = r.pc_value;
      f3 = ir[14:12];
      f7 = ir[31:25];
      imm_i = {{20{ir[31]}}, ir[31:20]};
      imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
      imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
      imm_u = {ir[31:12], 12'd0};
      imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
      op = OP_INVALID;
      res = '0;
      tgt = '0;
      sdata = '0;
      redir = 1'b0;
      taken = 1'b0;
      case (ir[6:0])
         OPC_LUI: begin
            op = OP_LUI;
            res = imm_u;
         end
         OPC_AUIPC: begin
            op = OP_AUIPC;
            res = pc + imm_u;
         end
         OPC_JAL: begin
            op = OP_JAL;
            res = pc + 32'd4;
            redir = 1'b1;
            tgt = pc + imm_j;
         end
         OPC_JALR: begin
            if (f3 == F3_JALR) begin
               op = OP_JALR;
               res = pc + 32'd4;
               redir = 1'b1;
               tgt = (a + imm_i) & CLEAR_BIT0;
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ: begin
                  op = OP_BEQ;
                  taken = (a == b);
               end
               F3_BNE: begin
                  op = OP_BNE;
                  taken = (a != b);
               end
               F3_BLT: begin
                  op = OP_BLT;
                  taken = ($signed(a) < $signed(b));
               end
               F3_BGE: begin
                  op = OP_BGE;
                  taken = !($signed(a) < $signed(b));
               end
               F3_BLTU: begin
                  op = OP_BLTU;
                  taken = (a < b);
               end
               F3_BGEU: begin
                  op = OP_BGEU;
                  taken = !(a < b);
               end
               default: ;
            endcase
            redir = taken;
            if (taken) tgt = pc + imm_b;
         end
         OPC_LOAD: begin
            case (f3)
               F3_LB:   op = OP_LB;
               F3_LH:   op = OP_LH;
               F3_LW:   op = OP_LW;
               F3_LBU:  op = OP_LBU;
               F3_LHU:  op = OP_LHU;
               default: ;
            endcase
            res = a + imm_i;
         end
         OPC_STORE: begin
            case (f3)
               F3_SB:   op = OP_SB;
               F3_SH:   op = OP_SH;
               F3_SW:   op = OP_SW;
               default: ;
            endcase
            res = a + imm_s;
            sdata = b;
         end
         OPC_OPIMM: begin
            case (f3)
               F3_ADD_SUB: op = OP_ADDI;
               F3_SLT:     op = OP_SLTI;
               F3_SLTU:    op = OP_SLTIU;
               F3_XOR:     op = OP_XORI;
               F3_OR:      op = OP_ORI;
               F3_AND:     op = OP_ANDI;
               F3_SLL:     if (f7 == F7_BASE) op = OP_SLLI;
               default: begin
                  if (f7 == F7_BASE) op = OP_SRLI;
                  else if (f7 == F7_ALT) op = OP_SRAI;
               end
            endcase
            // upper immediate bits only select the arithmetic shift
            res = alu_value(f3, (f3 == F3_SRL_SRA) && (f7 == F7_ALT), a, imm_i);
         end
         OPC_OP: begin
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD_SUB: op = OP_ADD;
                  F3_SLL:     op = OP_SLL;
                  F3_SLT:     op = OP_SLT;
                  F3_SLTU:    op = OP_SLTU;
                  F3_XOR:     op = OP_XOR;
                  F3_SRL_SRA: op = OP_SRL;
                  F3_OR:      op = OP_OR;
                  default:    op = OP_AND;
               endcase
            end else if (f7 == F7_ALT) begin
               if (f3 == F3_ADD_SUB) op = OP_SUB;
               else if (f3 == F3_SRL_SRA) op = OP_SRA;
            end
            res = alu_value(f3, f7 == F7_ALT, a, b);
         end
         default: ;
      endcase
      wr = (op != OP_INVALID) && (ir[6:0] != OPC_BRANCH) && (ir[6:0] != OPC_STORE);
      if (op == OP_INVALID) begin
         res = '0;
         tgt = '0;
         sdata = '0;
         redir = 1'b0;
      end
      o.result_value   = (ir[6:0] == OPC_BRANCH) ? 32'd0 : res;
      o.dest_reg       = wr ? ir[11:7] : 5'd0;
      o.writes_dest    = wr;
      o.operation_id   = op;
      o.redirect       = redir;
      o.target_address = redir ? tgt : 32'd0;
      o.store_data     = sdata;
      o.invalid        = (op == OP_INVALID);
      return o;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         // results pass the queue and result register, so none belongs to the request taken now
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.result_value !== want.result_value)
                  report_mismatch($sformatf("result_value %h, want %h",
                                            rsp_data.result_value, want.result_value));
               if (rsp_data.dest_reg !== want.dest_reg)
                  report_mismatch($sformatf("dest_reg %0d, want %0d",
                                            rsp_data.dest_reg, want.dest_reg));
               if (rsp_data.writes_dest !== want.writes_dest)
                  report_mismatch($sformatf("writes_dest %b, want %b",
                                            rsp_data.writes_dest, want.writes_dest));
               if (rsp_data.operation_id !== want.operation_id)
                  report_mismatch($sformatf("operation_id %0d, want %0d",
                                            rsp_data.operation_id, want.operation_id));
               if (rsp_data.redirect !== want.redirect)
                  report_mismatch($sformatf("redirect %b, want %b",
                                            rsp_data.redirect, want.redirect));
               if (rsp_data.target_address !== want.target_address)
                  report_mismatch($sformatf("target_address %h, want %h",
                                            rsp_data.target_address, want.target_address));
               if (rsp_data.store_data !== want.store_data)
                  report_mismatch($sformatf("store_data %h, want %h",
                                            rsp_data.store_data, want.store_data));
               if (rsp_data.invalid !== want.invalid)
                  report_mismatch($sformatf("invalid %b, want %b",
                                            rsp_data.invalid, want.invalid));
            end
         end
         if (start && !busy) expected_results.push_back(execute_instruction(req_data));
      end
      pending_count <= expected_results.size();
   end

endmodule

// File: test/testbench.sv
// stimulus and verdict for the rv32i decode/execute unit
`timescale 1ns / 100ps

module testbench;
   import rvx_pkg::*;
   import rv32i_tb_pkg::*;

   localparam int RANDOM_REQUESTS = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      pending_count;
   int      error_count;

   rv32i_decode_execute u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   rv32i_exec_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   always #5 clock = ~clock;

   // hold start until the block takes the request
   task automatic send_request(input logic [31:0] ir, input logic [31:0] a,
                               input logic [31:0] b, input logic [31:0] pc);
      req_type r;
      r.instruction_word = ir;
      r.src1_value = a;
      r.src2_value = b;
      r.pc_value = pc;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // sets the opcode and any funct3 and funct7 the operation uses in a random word
   function automatic logic [31:0] build_instruction(input logic [5:0] op,
                                                     input logic [31:0] w);
      logic [6:0] opc;
      logic [2:0] f3;
      logic [6:0] f7;
      logic       uses_f3, fix_f7;
      opc = OPC_OP;
      f3 = F3_ADD_SUB;
      f7 = F7_BASE;
      uses_f3 = 1'b1;
      fix_f7 = 1'b0;
      case (op)
         OP_LUI:   begin opc = OPC_LUI;   uses_f3 = 1'b0; end
         OP_AUIPC: begin opc = OPC_AUIPC; uses_f3 = 1'b0; end
         OP_JAL:   begin opc = OPC_JAL;   uses_f3 = 1'b0; end
         OP_JALR:  begin opc = OPC_JALR;  f3 = F3_JALR; end
         OP_BEQ:   begin opc = OPC_BRANCH; f3 = F3_BEQ;  end
         OP_BNE:   begin opc = OPC_BRANCH; f3 = F3_BNE;  end
         OP_BLT:   begin opc = OPC_BRANCH; f3 = F3_BLT;  end
         OP_BGE:   begin opc = OPC_BRANCH; f3 = F3_BGE;  end
         OP_BLTU:  begin opc = OPC_BRANCH; f3 = F3_BLTU; end
         OP_BGEU:  begin opc = OPC_BRANCH; f3 = F3_BGEU; end
         OP_LB:    begin opc = OPC_LOAD; f3 = F3_LB;  end
         OP_LH:    begin opc = OPC_LOAD; f3 = F3_LH;  end
         OP_LW:    begin opc = OPC_LOAD; f3 = F3_LW;  end
         OP_LBU:   begin opc = OPC_LOAD; f3 = F3_LBU; end
         OP_LHU:   begin opc = OPC_LOAD; f3 = F3_LHU; end
         OP_SB:    begin opc = OPC_STORE; f3 = F3_SB; end
         OP_SH:    begin opc = OPC_STORE; f3 = F3_SH; end
         OP_SW:    begin opc = OPC_STORE; f3 = F3_SW; end
         OP_ADDI:  begin opc = OPC_OPIMM; f3 = F3_ADD_SUB; end
         OP_SLTI:  begin opc = OPC_OPIMM; f3 = F3_SLT;  end
         OP_SLTIU: begin opc = OPC_OPIMM; f3 = F3_SLTU; end
         OP_XORI:  begin opc = OPC_OPIMM; f3 = F3_XOR;  end
         OP_ORI:   begin opc = OPC_OPIMM; f3 = F3_OR;   end
         OP_ANDI:  begin opc = OPC_OPIMM; f3 = F3_AND;  end
         OP_SLLI:  begin opc = OPC_OPIMM; f3 = F3_SLL; fix_f7 = 1'b1; end
         OP_SRLI:  begin opc = OPC_OPIMM; f3 = F3_SRL_SRA; fix_f7 = 1'b1; end
         OP_SRAI:  begin opc = OPC_OPIMM; f3 = F3_SRL_SRA; fix_f7 = 1'b1; f7 = F7_ALT; end
         OP_ADD:   begin f3 = F3_ADD_SUB; fix_f7 = 1'b1; end
         OP_SUB:   begin f3 = F3_ADD_SUB; fix_f7 = 1'b1; f7 = F7_ALT; end
         OP_SLL:   begin f3 = F3_SLL;  fix_f7 = 1'b1; end
         OP_SLT:   begin f3 = F3_SLT;  fix_f7 = 1'b1; end
         OP_SLTU:  begin f3 = F3_SLTU; fix_f7 = 1'b1; end
         OP_XOR:   begin f3 = F3_XOR;  fix_f7 = 1'b1; end
         OP_SRL:   begin f3 = F3_SRL_SRA; fix_f7 = 1'b1; end
         OP_SRA:   begin f3 = F3_SRL_SRA; fix_f7 = 1'b1; f7 = F7_ALT; end
         OP_OR:    begin f3 = F3_OR;  fix_f7 = 1'b1; end
         default:  begin f3 = F3_AND; fix_f7 = 1'b1; end
      endcase
      w[6:0] = opc;
      if (uses_f3) w[14:12] = f3;
      if (fix_f7) w[31:25] = f7;
      return w;
   endfunction

   // operand values lean toward the corners of signed and unsigned compares
   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0:       v = 32'h0000_0000;
         1:       v = 32'hFFFF_FFFF;
         2:       v = 32'h8000_0000;
         3:       v = 32'h7FFF_FFFF;
         4:       v = $urandom_range(0, 64);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      int          sent, burst, gap, waited;
      logic [31:0] ir, a, b;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, back to back
      send_request({20'hFFFFF, 5'd31, OPC_LUI}, 32'h0, 32'h0, 32'h0);
      send_request({20'h00001, 5'd1, OPC_AUIPC}, 32'h0, 32'h0, 32'hFFFF_FFFC);
      // most negative jump offset, link to x0
      send_request({1'b1, 10'd0, 1'b0, 8'd0, 5'd0, OPC_JAL}, 32'h0, 32'h0, 32'h0);
      // odd jalr target loses bit 0
      send_request({12'hFFF, 5'd2, F3_JALR, 5'd1, OPC_JALR}, 32'h1000_0002,
                   32'h0, 32'h4000);
      send_request({12'h004, 5'd2, ~F3_JALR, 5'd1, OPC_JALR}, 32'h100, 32'h0, 32'h0);
      send_request({1'b0, 6'h3F, 5'd2, 5'd1, F3_BEQ, 4'hF, 1'b1, OPC_BRANCH},
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000);
      send_request({7'h7F, 5'd2, 5'd1, F3_BNE, 5'h1F, OPC_BRANCH}, 32'h0, 32'h0, 32'h40);
      send_request({7'h40, 5'd2, 5'd1, F3_BLT, 5'd0, OPC_BRANCH},
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      send_request({7'h00, 5'd2, 5'd1, F3_BGEU, 5'd8, OPC_BRANCH},
                   32'h0, 32'hFFFF_FFFF, 32'h100);
      send_request({7'h00, 5'd2, 5'd1, F3_BLTU, 5'd8, OPC_BRANCH},
                   32'h0, 32'hFFFF_FFFF, 32'h100);
      send_request({7'h3F, 5'd2, 5'd1, F3_BGE, 5'h1E, OPC_BRANCH},
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      // funct3 unused by branches
      send_request({7'h00, 5'd2, 5'd1, F3_SLT, 5'd8, OPC_BRANCH}, 32'h1, 32'h1, 32'h0);
      send_request({12'h001, 5'd3, F3_LW, 5'd4, OPC_LOAD}, 32'hFFFF_FFFF, 32'h0, 32'h0);
      // funct3 unused by loads
      send_request({12'h001, 5'd3, F3_SLTU, 5'd4, OPC_LOAD}, 32'h10, 32'h0, 32'h0);
      send_request({7'h40, 5'd5, 5'd6, F3_SW, 5'd0, OPC_STORE}, 32'h0, 32'hDEAD_BEEF, 32'h0);
      // funct3 unused by stores
      send_request({7'h00, 5'd5, 5'd6, F3_SLTU, 5'd4, OPC_STORE}, 32'h8, 32'h55, 32'h0);
      send_request({F7_ALT, 5'd31, 5'd7, F3_SRL_SRA, 5'd8, OPC_OPIMM},
                   32'h8000_0000, 32'h0, 32'h0);
      send_request({F7_ALT, 5'd3, 5'd7, F3_SLL, 5'd8, OPC_OPIMM}, 32'h1, 32'h0, 32'h0);
      send_request({12'hFFF, 5'd7, F3_SLTU, 5'd9, OPC_OPIMM}, 32'hFFFF_FFFE, 32'h0, 32'h0);
      send_request({12'h7FF, 5'd7, F3_ADD_SUB, 5'd9, OPC_OPIMM}, 32'h7FFF_FFFF, 32'h0, 32'h0);
      // immediate with the alternate funct7 pattern still adds
      send_request({12'h400, 5'd7, F3_ADD_SUB, 5'd9, OPC_OPIMM}, 32'h1, 32'h0, 32'h0);
      send_request({F7_ALT, 5'd2, 5'd1, F3_ADD_SUB, 5'd0, OPC_OP}, 32'h0, 32'h1, 32'h0);
      // shift amount comes from the low five bits only
      send_request({F7_ALT, 5'd2, 5'd1, F3_SRL_SRA, 5'd10, OPC_OP},
                   32'h8000_0000, 32'hFFFF_FFE1, 32'h0);
      send_request({F7_ALT, 5'd2, 5'd1, F3_SLL, 5'd10, OPC_OP}, 32'h1, 32'h1, 32'h0);
      send_request({7'h01, 5'd2, 5'd1, F3_ADD_SUB, 5'd10, OPC_OP}, 32'h3, 32'h4, 32'h0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'h0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h4);

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 32);
         for (int i = 0; i < burst; i++) begin
            if ($urandom_range(0, 99) < 85) begin
               ir = build_instruction(6'($urandom_range(OP_LUI, OP_AND)), $urandom);
            end else begin
               // noise: real opcode with random funct fields, or any word at all
               ir = $urandom;
               if ($urandom_range(0, 1)) begin
                  ir = build_instruction(6'($urandom_range(OP_LUI, OP_AND)), $urandom);
                  ir[14:12] = 3'($urandom);
                  ir[31:25] = 7'($urandom);
               end
            end
            a = pick_operand();
            b = ($urandom_range(0, 3) == 0) ? a : pick_operand();
            send_request(ir, a, b, pick_operand());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            req_data <= {$urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(posedge clock);
         end
      end

      start <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_count != 0 && waited < 100);
      repeat (4) @(posedge clock);

      if (error_count == 0 && pending_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
